// ===== hw/rtl/ipv4hp_pkg.sv =====
// Shared types and constants for the IPv4 header parser.
// No dependencies; every file but ipv4hp_if takes names from here.
package ipv4hp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_PUSH    = 3;
    localparam int PUSH_W      = $clog2(MAX_PUSH + 1);

    localparam logic [5:0]  MIN_HEADER   = 6'd20;
    localparam logic [15:0] COUNT_MAX    = 16'hffff;
    localparam logic [15:0] SUM_GOOD     = 16'hffff;
    localparam logic [7:0]  IHL_MASK     = 8'h0f;
    localparam logic [7:0]  DSCP_MASK    = 8'hfc;
    localparam logic [7:0]  ECN_MASK     = 8'h03;
    localparam logic [15:0] DF_MASK      = 16'h4000;
    localparam logic [15:0] MF_MASK      = 16'h2000;
    localparam logic [15:0] OFFSET_MASK  = 16'h1fff;
    localparam logic [7:0]  OPT_EOOL     = 8'd0;
    localparam logic [7:0]  OPT_NOP      = 8'd1;
    localparam logic [7:0]  OPT_MIN_LEN  = 8'd2;

    typedef enum logic [2:0] {
        KIND_SUMMARY   = 3'd0,
        KIND_OPT_TYPE  = 3'd1,
        KIND_OPT_VALUE = 3'd2,
        KIND_PAYLOAD   = 3'd3,
        KIND_END       = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_SHORT      = 3'd1,
        ERR_HDR_LEN    = 3'd2,
        ERR_CHECKSUM   = 3'd3,
        ERR_TOTAL_LEN  = 3'd4,
        ERR_OPTION     = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } t_opt_phase;

    typedef struct packed {
        t_kind       kind;
        t_err        error_code;
        logic [5:0]  dscp_value;
        logic [1:0]  ecn_value;
        logic [15:0] ident_value;
        logic [1:0]  frag_flags;
        logic [12:0] frag_offset;
        logic [7:0]  hop_limit;
        logic [7:0]  proto_number;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [7:0]  item_byte;
    } t_result;

    // results produced by one accepted byte, in delivery order
    typedef struct packed {
        logic [PUSH_W-1:0]            count;
        t_result [MAX_PUSH-1:0]       items;
    } t_push;

endpackage

// ===== hw/rtl/ipv4hp_if.sv =====
// Handshake channels of the IPv4 header parser: byte input and result output.
// Depends on ipv4hp_pkg for nothing but shares its field widths.
interface ipv4hp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, in_byte, last_byte, input ready);
    modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface ipv4hp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  error_code;
    logic [5:0]  dscp_value;
    logic [1:0]  ecn_value;
    logic [15:0] ident_value;
    logic [1:0]  frag_flags;
    logic [12:0] frag_offset;
    logic [7:0]  hop_limit;
    logic [7:0]  proto_number;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [7:0]  item_byte;

    modport source (output valid, kind, error_code, dscp_value, ecn_value, ident_value,
                    frag_flags, frag_offset, hop_limit, proto_number, source_addr,
                    dest_addr, item_byte, input ready);
    modport sink   (input valid, kind, error_code, dscp_value, ecn_value, ident_value,
                    frag_flags, frag_offset, hop_limit, proto_number, source_addr,
                    dest_addr, item_byte, output ready);
endinterface

// ===== hw/rtl/ipv4hp_parse.sv =====
// Per-byte parse step: packet state registers and the update/emit logic.
// Depends on ipv4hp_pkg; feeds up to three results per byte to the result queue.
module ipv4hp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output ipv4hp_pkg::t_push  o_push
);

    logic                      r_check_en;
    logic [15:0]               r_byte_count, n_byte_count;
    logic [5:0]                r_hdr_bytes, n_hdr_bytes;
    logic [15:0]               r_pkt_len, n_pkt_len;
    logic [15:0]               r_sum, n_sum;
    logic [7:0]                r_high_hold, n_high_hold;
    logic [7:0]                r_tos, n_tos;
    logic [15:0]               r_ident, n_ident;
    logic [15:0]               r_frag, n_frag;
    logic [7:0]                r_ttl, n_ttl;
    logic [7:0]                r_proto, n_proto;
    logic [7:0]                r_opt_type, n_opt_type;
    logic [63:0]               r_addr, n_addr;
    ipv4hp_pkg::t_opt_phase    r_phase, n_phase;
    logic [7:0]                r_opt_left, n_opt_left;
    ipv4hp_pkg::t_err          r_err, n_err;

    function automatic ipv4hp_pkg::t_err raise_err(input ipv4hp_pkg::t_err cur,
                                                   input ipv4hp_pkg::t_err code);
        if (cur == ipv4hp_pkg::ERR_NONE || code < cur) begin
            return code;
        end
        return cur;
    endfunction

    function automatic ipv4hp_pkg::t_result mk_item(input ipv4hp_pkg::t_kind kind,
                                                    input ipv4hp_pkg::t_err err,
                                                    input logic [7:0] item);
        ipv4hp_pkg::t_result r;
        r = '0;
        r.kind       = kind;
        r.error_code = err;
        r.item_byte  = item;
        return r;
    endfunction

    always_comb begin
        logic [15:0]         b;
        logic [16:0]         sum_wide;
        logic [16:0]         opt_end;
        logic [15:0]         count;
        ipv4hp_pkg::t_result summary;

        b            = r_byte_count;
        n_byte_count = r_byte_count;
        n_hdr_bytes  = r_hdr_bytes;
        n_pkt_len    = r_pkt_len;
        n_sum        = r_sum;
        n_high_hold  = r_high_hold;
        n_tos        = r_tos;
        n_ident      = r_ident;
        n_frag       = r_frag;
        n_ttl        = r_ttl;
        n_proto      = r_proto;
        n_opt_type   = r_opt_type;
        n_addr       = r_addr;
        n_phase      = r_phase;
        n_opt_left   = r_opt_left;
        n_err        = r_err;
        o_push       = '0;
        sum_wide     = '0;
        opt_end      = 17'(b) + 17'(i_byte) - 17'd1;
        count        = '0;
        summary      = '0;

        if (i_accept) begin
            if (b >= ipv4hp_pkg::COUNT_MAX) begin
                n_byte_count = ipv4hp_pkg::COUNT_MAX;
                n_err = raise_err(n_err, ipv4hp_pkg::ERR_TOTAL_LEN);
            end else begin
                n_byte_count = b + 16'd1;
            end

            if (b == 16'd0) begin
                n_hdr_bytes = {i_byte[3:0] & ipv4hp_pkg::IHL_MASK[3:0], 2'b00};
                if (n_hdr_bytes < ipv4hp_pkg::MIN_HEADER) begin
                    n_err = raise_err(n_err, ipv4hp_pkg::ERR_HDR_LEN);
                end
            end
            if (b == 16'd1) n_tos = i_byte;
            if (b == 16'd2 || b == 16'd3) n_pkt_len = {r_pkt_len[7:0], i_byte};
            if (b == 16'd4 || b == 16'd5) n_ident = {r_ident[7:0], i_byte};
            if (b == 16'd6 || b == 16'd7) n_frag = {r_frag[7:0], i_byte};
            if (b == 16'd8) n_ttl = i_byte;
            if (b == 16'd9) n_proto = i_byte;
            if (b >= 16'd12 && b < 16'd20) n_addr = {r_addr[55:0], i_byte};

            // ones-complement sum over big-endian 16-bit header words
            if (b < 16'(n_hdr_bytes)) begin
                if (!b[0]) begin
                    n_high_hold = i_byte;
                end else begin
                    sum_wide = 17'(r_sum) + 17'({r_high_hold, i_byte});
                    n_sum = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
                end
            end

            // option walk
            if (n_err == ipv4hp_pkg::ERR_NONE && b >= 16'd20 && b < 16'(n_hdr_bytes)) begin
                case (r_phase)
                    ipv4hp_pkg::PH_LEN: begin
                        if (i_byte < ipv4hp_pkg::OPT_MIN_LEN || opt_end > 17'(n_hdr_bytes)) begin
                            n_err = raise_err(n_err, ipv4hp_pkg::ERR_OPTION);
                        end else begin
                            o_push.items[o_push.count] = mk_item(ipv4hp_pkg::KIND_OPT_TYPE,
                                                                 ipv4hp_pkg::ERR_NONE, r_opt_type);
                            o_push.count = o_push.count + 1'b1;
                            n_opt_left = i_byte - ipv4hp_pkg::OPT_MIN_LEN;
                            n_phase = (n_opt_left != 8'd0) ? ipv4hp_pkg::PH_VALUE
                                                           : ipv4hp_pkg::PH_TYPE;
                        end
                    end
                    ipv4hp_pkg::PH_VALUE: begin
                        o_push.items[o_push.count] = mk_item(ipv4hp_pkg::KIND_OPT_VALUE,
                                                             ipv4hp_pkg::ERR_NONE, i_byte);
                        o_push.count = o_push.count + 1'b1;
                        n_opt_left = r_opt_left - 8'd1;
                        if (n_opt_left == 8'd0) n_phase = ipv4hp_pkg::PH_TYPE;
                    end
                    default: begin
                        n_phase = ipv4hp_pkg::PH_TYPE;
                        if (i_byte == ipv4hp_pkg::OPT_EOOL) begin
                            // padding, dropped
                        end else if (i_byte == ipv4hp_pkg::OPT_NOP) begin
                            o_push.items[o_push.count] = mk_item(ipv4hp_pkg::KIND_OPT_TYPE,
                                                                 ipv4hp_pkg::ERR_NONE, i_byte);
                            o_push.count = o_push.count + 1'b1;
                        end else if (b + 16'd1 == 16'(n_hdr_bytes)) begin
                            // multi-byte option with no room for its length
                            n_err = raise_err(n_err, ipv4hp_pkg::ERR_OPTION);
                        end else begin
                            n_opt_type = i_byte;
                            n_phase = ipv4hp_pkg::PH_LEN;
                        end
                    end
                endcase
            end

            if (n_hdr_bytes >= ipv4hp_pkg::MIN_HEADER && b + 16'd1 == 16'(n_hdr_bytes)) begin
                if (r_check_en && n_sum != ipv4hp_pkg::SUM_GOOD) begin
                    n_err = raise_err(n_err, ipv4hp_pkg::ERR_CHECKSUM);
                end
                if (n_err == ipv4hp_pkg::ERR_NONE) begin
                    summary = mk_item(ipv4hp_pkg::KIND_SUMMARY, ipv4hp_pkg::ERR_NONE, 8'd0);
                    summary.dscp_value   = 6'((n_tos & ipv4hp_pkg::DSCP_MASK) >> 2);
                    summary.ecn_value    = 2'(n_tos & ipv4hp_pkg::ECN_MASK);
                    summary.ident_value  = n_ident;
                    summary.frag_flags   = {(n_frag & ipv4hp_pkg::DF_MASK) != 16'd0,
                                            (n_frag & ipv4hp_pkg::MF_MASK) != 16'd0};
                    summary.frag_offset  = 13'(n_frag & ipv4hp_pkg::OFFSET_MASK);
                    summary.hop_limit    = n_ttl;
                    summary.proto_number = n_proto;
                    summary.source_addr  = n_addr[63:32];
                    summary.dest_addr    = n_addr[31:0];
                    o_push.items[o_push.count] = summary;
                    o_push.count = o_push.count + 1'b1;
                end
            end else if (n_hdr_bytes >= ipv4hp_pkg::MIN_HEADER && b >= 16'(n_hdr_bytes)
                         && n_err == ipv4hp_pkg::ERR_NONE) begin
                if (b >= n_pkt_len) begin
                    n_err = raise_err(n_err, ipv4hp_pkg::ERR_TOTAL_LEN);
                end else begin
                    o_push.items[o_push.count] = mk_item(ipv4hp_pkg::KIND_PAYLOAD,
                                                         ipv4hp_pkg::ERR_NONE, i_byte);
                    o_push.count = o_push.count + 1'b1;
                end
            end

            if (i_last) begin
                count = n_byte_count;
                if (count < 16'(n_hdr_bytes)) n_err = raise_err(n_err, ipv4hp_pkg::ERR_HDR_LEN);
                if (count != n_pkt_len) n_err = raise_err(n_err, ipv4hp_pkg::ERR_TOTAL_LEN);
                if (count < 16'(ipv4hp_pkg::MIN_HEADER)) n_err = ipv4hp_pkg::ERR_SHORT;
                o_push.items[o_push.count] = mk_item(ipv4hp_pkg::KIND_END, n_err, 8'd0);
                o_push.count = o_push.count + 1'b1;
                // packet done: back to the reset state
                n_byte_count = '0;
                n_hdr_bytes  = '0;
                n_pkt_len    = '0;
                n_sum        = '0;
                n_high_hold  = '0;
                n_phase      = ipv4hp_pkg::PH_TYPE;
                n_opt_left   = '0;
                n_err        = ipv4hp_pkg::ERR_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_en   <= 1'b1;
            r_byte_count <= '0;
            r_hdr_bytes  <= '0;
            r_pkt_len    <= '0;
            r_sum        <= '0;
            r_high_hold  <= '0;
            r_phase      <= ipv4hp_pkg::PH_TYPE;
            r_opt_left   <= '0;
            r_err        <= ipv4hp_pkg::ERR_NONE;
        end else begin
            if (i_cfg_we) r_check_en <= i_cfg_wdata;
            r_byte_count <= n_byte_count;
            r_hdr_bytes  <= n_hdr_bytes;
            r_pkt_len    <= n_pkt_len;
            r_sum        <= n_sum;
            r_high_hold  <= n_high_hold;
            r_phase      <= n_phase;
            r_opt_left   <= n_opt_left;
            r_err        <= n_err;
        end
    end

    // header fields; always rewritten before a summary can read them
    always_ff @(posedge i_clk) begin
        r_tos      <= n_tos;
        r_ident    <= n_ident;
        r_frag     <= n_frag;
        r_ttl      <= n_ttl;
        r_proto    <= n_proto;
        r_opt_type <= n_opt_type;
        r_addr     <= n_addr;
    end

    a_last_ends_with_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |-> (o_push.count != '0 &&
            o_push.items[2'(o_push.count - 1'b1)].kind == ipv4hp_pkg::KIND_END))
        else $error("last byte did not end with a status request");

    a_last_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_byte_count == '0 && r_err == ipv4hp_pkg::ERR_NONE))
        else $error("packet state not cleared after last byte");

    a_swallow_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last && r_err != ipv4hp_pkg::ERR_NONE) |-> (o_push.count == '0))
        else $error("request emitted while an error is latched");

endmodule

// ===== hw/rtl/ipv4hp_resq.sv =====
// Result queue: takes up to three results per cycle, delivers one per cycle when ready.
// Depends on ipv4hp_pkg and the result channel interface.
module ipv4hp_resq #(
    parameter int DEPTH = ipv4hp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ipv4hp_pkg::t_push  i_push,
    output logic               o_space,
    ipv4hp_result_if.source    o_out
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ipv4hp_pkg::t_result r_mem [DEPTH];
    logic [IW-1:0]       r_head, n_head;
    logic [IW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_count, n_count;
    logic                pop;
    ipv4hp_pkg::t_result head_item;

    function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                           input logic [ipv4hp_pkg::PUSH_W-1:0] k);
        logic [IW:0] s;
        s = {1'b0, base} + (IW+1)'(k);
        if (s >= (IW+1)'(DEPTH)) s = s - (IW+1)'(DEPTH);
        return s[IW-1:0];
    endfunction

    // room for a worst-case byte regardless of what drains this cycle
    assign o_space = (r_count <= CW'(DEPTH - ipv4hp_pkg::MAX_PUSH));
    assign pop     = o_out.valid && o_out.ready;

    always_comb begin
        n_head  = pop ? slot(r_head, ipv4hp_pkg::PUSH_W'(1)) : r_head;
        n_tail  = slot(r_tail, i_push.count);
        n_count = r_count + CW'(i_push.count) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ipv4hp_pkg::MAX_PUSH; k++) begin
            if (ipv4hp_pkg::PUSH_W'(k) < i_push.count) begin
                r_mem[slot(r_tail, ipv4hp_pkg::PUSH_W'(k))] <= i_push.items[k];
            end
        end
    end

    assign head_item         = r_mem[r_head];
    assign o_out.valid       = (r_count != '0);
    assign o_out.kind        = head_item.kind;
    assign o_out.error_code  = head_item.error_code;
    assign o_out.dscp_value  = head_item.dscp_value;
    assign o_out.ecn_value   = head_item.ecn_value;
    assign o_out.ident_value = head_item.ident_value;
    assign o_out.frag_flags  = head_item.frag_flags;
    assign o_out.frag_offset = head_item.frag_offset;
    assign o_out.hop_limit   = head_item.hop_limit;
    assign o_out.proto_number = head_item.proto_number;
    assign o_out.source_addr = head_item.source_addr;
    assign o_out.dest_addr   = head_item.dest_addr;
    assign o_out.item_byte   = head_item.item_byte;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != '0) |-> o_space)
        else $error("result queue written without space");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue count out of range");

    a_drain_to_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(1) && pop && i_push.count == '0) |=> !o_out.valid)
        else $error("queue still valid after last entry drained");

endmodule

// ===== hw/rtl/ipv4_header_parser.sv =====
// IPv4 header parser top level: byte channel in, result channel out, one config bit.
// Latency: with the queue empty, the first result of a byte is on the output the cycle
//   after the byte is accepted; its further results follow one per cycle when ready.
// Throughput: one byte per cycle; up to three results per byte, drained one per cycle
//   when ready from a QUEUE_DEPTH-entry queue; input stalls without room for three.
// Reset (synchronous, active low): packet state cleared, queue empty, checksum check on.
module ipv4_header_parser #(
    parameter int QUEUE_DEPTH = ipv4hp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    ipv4hp_byte_if.sink      i_in,
    ipv4hp_result_if.source  o_out
);

    ipv4hp_pkg::t_push push;
    logic              space;
    logic              accept;

    assign i_in.ready = space;
    assign accept     = i_in.valid && space;

    ipv4hp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_byte      (i_in.in_byte),
        .i_last      (i_in.last_byte),
        .o_push      (push)
    );

    ipv4hp_resq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule

// ===== tb/tb_ipv4_header_parser.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ipv4_header_parser: packet bytes in, parse results out.
// Depends on ipv4hp_pkg and the channel interfaces in ipv4hp_if.

class parse_scoreboard;
    bit                     sum_check_on = 1'b1;
    ipv4hp_pkg::t_result    owed_results[$];
    int                     byte_total;
    int                     result_total;
    int                     fail_total;

    bit [15:0]              byte_cnt;
    bit [5:0]               hdr_len;
    bit [15:0]              total_len;
    bit [16:0]              hdr_sum;
    bit [7:0]               sum_hi;
    bit [63:0]              lead_bytes;     // header bytes 0..7
    bit [15:0]              ttl_proto;      // header bytes 8..9
    bit [7:0]               opt_type;
    bit [63:0]              addr_pair;      // header bytes 12..19
    ipv4hp_pkg::t_opt_phase opt_phase;
    bit [7:0]               opt_left;
    ipv4hp_pkg::t_err       status;

    function new();
        restart();
    endfunction

    function void restart();
        byte_cnt   = '0;
        hdr_len    = '0;
        total_len  = '0;
        hdr_sum    = '0;
        sum_hi     = '0;
        lead_bytes = '0;
        ttl_proto  = '0;
        opt_type   = '0;
        addr_pair  = '0;
        opt_phase  = ipv4hp_pkg::PH_TYPE;
        opt_left   = '0;
        status     = ipv4hp_pkg::ERR_NONE;
    endfunction

    // lowest code wins
    function void flag(ipv4hp_pkg::t_err code);
        if (status == ipv4hp_pkg::ERR_NONE || code < status)
            status = code;
    endfunction

    function void queue_result(ipv4hp_pkg::t_result r);
        owed_results.insert(owed_results.size(), r);
    endfunction

    function void owe(ipv4hp_pkg::t_kind k, ipv4hp_pkg::t_err e, bit [7:0] item);
        ipv4hp_pkg::t_result r;
        r            = '0;
        r.kind       = k;
        r.error_code = e;
        r.item_byte  = item;
        queue_result(r);
    endfunction

    function void walk_option(int b, bit [7:0] d);
        case (opt_phase)
            ipv4hp_pkg::PH_LEN: begin
                if (d < ipv4hp_pkg::OPT_MIN_LEN || (b - 1) + int'(d) > int'(hdr_len)) begin
                    flag(ipv4hp_pkg::ERR_OPTION);
                end else begin
                    owe(ipv4hp_pkg::KIND_OPT_TYPE, ipv4hp_pkg::ERR_NONE, opt_type);
                    opt_left  = d - ipv4hp_pkg::OPT_MIN_LEN;
                    opt_phase = (opt_left != 0) ? ipv4hp_pkg::PH_VALUE : ipv4hp_pkg::PH_TYPE;
                end
            end
            ipv4hp_pkg::PH_VALUE: begin
                owe(ipv4hp_pkg::KIND_OPT_VALUE, ipv4hp_pkg::ERR_NONE, d);
                opt_left = opt_left - 8'd1;
                if (opt_left == 0)
                    opt_phase = ipv4hp_pkg::PH_TYPE;
            end
            default: begin
                opt_phase = ipv4hp_pkg::PH_TYPE;
                if (d == ipv4hp_pkg::OPT_NOP) begin
                    owe(ipv4hp_pkg::KIND_OPT_TYPE, ipv4hp_pkg::ERR_NONE, d);
                end else if (d != ipv4hp_pkg::OPT_EOOL) begin
                    // a length byte can no longer fit inside the header
                    if (b + 1 == int'(hdr_len)) begin
                        flag(ipv4hp_pkg::ERR_OPTION);
                    end else begin
                        opt_type  = d;
                        opt_phase = ipv4hp_pkg::PH_LEN;
                    end
                end
            end
        endcase
    endfunction

    function void parse_byte(bit [7:0] d, bit is_last);
        int                  b;
        ipv4hp_pkg::t_result s;
        b = byte_cnt;
        byte_total++;
        if (byte_cnt == 16'hffff)
            flag(ipv4hp_pkg::ERR_TOTAL_LEN);
        else
            byte_cnt++;

        if (b == 0) begin
            hdr_len = {d[3:0], 2'b00};
            if (hdr_len < 20)
                flag(ipv4hp_pkg::ERR_HDR_LEN);
        end
        if (b < 8)
            lead_bytes = {lead_bytes[55:0], d};
        if (b == 2 || b == 3)
            total_len = {total_len[7:0], d};
        if (b == 8 || b == 9)
            ttl_proto = {ttl_proto[7:0], d};
        if (b >= 12 && b < 20)
            addr_pair = {addr_pair[55:0], d};

        if (b < int'(hdr_len)) begin
            if (!b[0]) begin
                sum_hi = d;
            end else begin
                hdr_sum = hdr_sum + {sum_hi, d};
                if (hdr_sum[16])
                    hdr_sum = {1'b0, hdr_sum[15:0]} + 17'd1;
            end
        end

        if (status == ipv4hp_pkg::ERR_NONE && b >= 20 && b < int'(hdr_len))
            walk_option(b, d);

        if (hdr_len >= 20 && b + 1 == int'(hdr_len)) begin
            if (sum_check_on && hdr_sum[15:0] != 16'hffff)
                flag(ipv4hp_pkg::ERR_CHECKSUM);
            if (status == ipv4hp_pkg::ERR_NONE) begin
                s              = '0;
                s.kind         = ipv4hp_pkg::KIND_SUMMARY;
                s.error_code   = ipv4hp_pkg::ERR_NONE;
                s.dscp_value   = lead_bytes[55:50];
                s.ecn_value    = lead_bytes[49:48];
                s.ident_value  = lead_bytes[31:16];
                s.frag_flags   = {lead_bytes[14], lead_bytes[13]};
                s.frag_offset  = lead_bytes[12:0];
                s.hop_limit    = ttl_proto[15:8];
                s.proto_number = ttl_proto[7:0];
                s.source_addr  = addr_pair[63:32];
                s.dest_addr    = addr_pair[31:0];
                queue_result(s);
            end
        end else if (hdr_len >= 20 && b >= int'(hdr_len) && status == ipv4hp_pkg::ERR_NONE) begin
            if (b >= int'(total_len))
                flag(ipv4hp_pkg::ERR_TOTAL_LEN);
            else
                owe(ipv4hp_pkg::KIND_PAYLOAD, ipv4hp_pkg::ERR_NONE, d);
        end

        if (is_last) begin
            if (byte_cnt < hdr_len)
                flag(ipv4hp_pkg::ERR_HDR_LEN);
            if (byte_cnt != total_len)
                flag(ipv4hp_pkg::ERR_TOTAL_LEN);
            if (byte_cnt < 20)
                status = ipv4hp_pkg::ERR_SHORT;
            owe(ipv4hp_pkg::KIND_END, status, 8'h00);
            restart();
        end
    endfunction

    function void expect_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_total++;
        end
    endfunction

    function void match_result(ipv4hp_pkg::t_result got);
        ipv4hp_pkg::t_result want;
        result_total++;
        if (owed_results.size() == 0) begin
            $error("unexpected result: kind 0x%0h item 0x%0h", got.kind, got.item_byte);
            fail_total++;
        end else begin
            want = owed_results.pop_front();
            expect_field("kind", want.kind, got.kind);
            expect_field("error_code", want.error_code, got.error_code);
            expect_field("dscp_value", want.dscp_value, got.dscp_value);
            expect_field("ecn_value", want.ecn_value, got.ecn_value);
            expect_field("ident_value", want.ident_value, got.ident_value);
            expect_field("frag_flags", want.frag_flags, got.frag_flags);
            expect_field("frag_offset", want.frag_offset, got.frag_offset);
            expect_field("hop_limit", want.hop_limit, got.hop_limit);
            expect_field("proto_number", want.proto_number, got.proto_number);
            expect_field("source_addr", want.source_addr, got.source_addr);
            expect_field("dest_addr", want.dest_addr, got.dest_addr);
            expect_field("item_byte", want.item_byte, got.item_byte);
        end
    endfunction
endclass

module tb_ipv4_header_parser;

    typedef logic [7:0] octet_q [$];

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEM_TARGET   = 330;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ipv4hp_byte_if   in_ch ();
    ipv4hp_result_if out_ch ();

    parse_scoreboard board = new();

    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;
    bit hold_request  = 1'b0;
    int packets_sent  = 0;
    int sum_writes    = 0;
    int idle_run;

    ipv4_header_parser uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- driving ----------------

    function automatic void add_octet(ref octet_q q, input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    task automatic send_byte(logic [7:0] d, logic is_last);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= d;
        in_ch.last_byte <= is_last;
        do @(posedge clk); while (!in_ch.ready);
        board.parse_byte(d, is_last);
    endtask

    task automatic send_packet(input octet_q p);
        int i;
        for (i = 0; i < p.size(); i++)
            send_byte(p[i], i == p.size() - 1);
        packets_sent++;
    endtask

    // hold the sender until every owed result is out, plus the output latency
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (board.owed_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_sum_check(bit on);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.sum_check_on = on;
        sum_writes++;
    endtask

    // fill < 0 randomizes fixed fields; else all but length and checksum take that byte
    function automatic octet_q build_packet(int ihl, octet_q opts, int payload_len,
                                            int length_skew, bit sum_ok, int fill);
        octet_q     p;
        int         hlen;
        int         total;
        int         i;
        bit [16:0]  acc;
        bit [15:0]  csum;
        hlen  = ihl * 4;
        total = (hlen < 20 ? 20 : hlen) + payload_len + length_skew;
        add_octet(p, {4'h4, 4'(ihl)});
        for (i = 1; i < 20; i++)
            add_octet(p, fill < 0 ? 8'($urandom) : 8'(fill));
        p[2]  = total[15:8];
        p[3]  = total[7:0];
        p[10] = 8'h00;
        p[11] = 8'h00;
        for (i = 20; i < hlen; i++)
            add_octet(p, (i - 20 < opts.size()) ? opts[i - 20] : ipv4hp_pkg::OPT_EOOL);
        acc = '0;
        for (i = 0; i + 1 < hlen; i += 2) begin
            acc = acc + {p[i], p[i + 1]};
            if (acc[16])
                acc = {1'b0, acc[15:0]} + 17'd1;
        end
        csum = ~acc[15:0];
        if (!sum_ok)
            csum ^= 16'(1 << $urandom_range(0, 15));
        p[10] = csum[15:8];
        p[11] = csum[7:0];
        for (i = 0; i < payload_len; i++)
            add_octet(p, 8'($urandom));
        return p;
    endfunction

    // well-formed option list that exactly fills room bytes
    function automatic octet_q random_options(int room);
        octet_q o;
        int     len;
        int     pick;
        while (o.size() < room) begin
            pick = $urandom_range(0, 5);
            len  = room - o.size();
            if (pick == 0 || len < 2) begin
                add_octet(o, ipv4hp_pkg::OPT_NOP);
            end else if (pick == 1) begin
                add_octet(o, ipv4hp_pkg::OPT_EOOL);
            end else begin
                len = (pick == 5) ? len : $urandom_range(2, len < 12 ? len : 12);
                add_octet(o, 8'($urandom_range(2, 255)));
                add_octet(o, 8'(len));
                repeat (len - 2) add_octet(o, 8'($urandom));
            end
        end
        return o;
    endfunction

    // ---------------- result side ----------------

    initial begin
        ipv4hp_pkg::t_result got;
        int                  gap;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = receiver_gaps ? $urandom_range(0, 10) : 0;
            if (hold_request) begin
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got.kind         = ipv4hp_pkg::t_kind'(out_ch.kind);
            got.error_code   = ipv4hp_pkg::t_err'(out_ch.error_code);
            got.dscp_value   = out_ch.dscp_value;
            got.ecn_value    = out_ch.ecn_value;
            got.ident_value  = out_ch.ident_value;
            got.frag_flags   = out_ch.frag_flags;
            got.frag_offset  = out_ch.frag_offset;
            got.hop_limit    = out_ch.hop_limit;
            got.proto_number = out_ch.proto_number;
            got.source_addr  = out_ch.source_addr;
            got.dest_addr    = out_ch.dest_addr;
            got.item_byte    = out_ch.item_byte;
            board.match_result(got);
        end
    end

    // any request on either side restarts the count
    initial begin
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $error("no request moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ---------------- stimulus ----------------

    initial begin
        octet_q pkt;
        octet_q opts;
        octet_q no_opts;
        int     pick;
        int     ihl;

        in_ch.valid     <= 1'b0;
        in_ch.in_byte   <= 8'h00;
        in_ch.last_byte <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 1'b0;
        rst_n           <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        set_sum_check(1'b1);

        // bare header with fixed fields at zero but version/IHL, length and checksum
        send_packet(build_packet(5, no_opts, 0, 0, 1'b1, 0));

        // NOP kept, EOOL dropped, two-byte option ending right at the header end
        opts = {ipv4hp_pkg::OPT_NOP, ipv4hp_pkg::OPT_EOOL, 8'h83, 8'd2};
        send_packet(build_packet(6, opts, 2, 0, 1'b1, -1));

        // widest header, one option spanning all option bytes; output held off
        // meanwhile while the sender keeps going, so the input backs up
        opts = {8'hff, 8'd40};
        repeat (38) add_octet(opts, 8'($urandom));
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        send_packet(build_packet(15, opts, 2, 0, 1'b1, -1));
        sender_gaps  = 1'b1;

        // option length of zero
        opts = {8'h44, 8'd0};
        send_packet(build_packet(6, opts, 0, 0, 1'b1, -1));

        // option reaching past the header end
        opts = {8'h07, 8'd6};
        send_packet(build_packet(6, opts, 0, 0, 1'b1, -1));

        // multi-byte option type in the final header byte
        opts = {ipv4hp_pkg::OPT_NOP, ipv4hp_pkg::OPT_NOP, ipv4hp_pkg::OPT_NOP, 8'h86};
        send_packet(build_packet(6, opts, 0, 0, 1'b1, -1));

        // single-byte packet
        pkt = build_packet(5, no_opts, 0, 0, 1'b1, -1);
        send_packet(pkt[0:0]);

        // IHL below five
        send_packet(build_packet(4, no_opts, 0, 0, 1'b1, -1));

        // packet ends inside the options
        pkt = build_packet(6, random_options(4), 0, 0, 1'b1, -1);
        send_packet(pkt[0:21]);

        // checksum wrong with checking on
        send_packet(build_packet(5, no_opts, 0, 0, 1'b0, -1));

        // total length beyond the bytes sent, then short of them
        send_packet(build_packet(5, no_opts, 0, 3, 1'b1, -1));
        send_packet(build_packet(5, no_opts, 4, -2, 1'b1, -1));

        // checking off: a wrong sum goes through
        set_sum_check(1'b0);
        send_packet(build_packet(5, no_opts, 0, 0, 1'b0, -1));
        set_sum_check(1'b1);

        while (board.byte_total < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0)
                set_sum_check($urandom_range(0, 1));
            if ($urandom_range(0, 5) == 0) begin
                sender_gaps   = $urandom_range(0, 1);
                receiver_gaps = $urandom_range(0, 1);
            end
            pick = $urandom_range(0, 9);
            ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(5, 7);
            if (pick < 7) begin
                pkt = build_packet(ihl, random_options(ihl * 4 - 20), $urandom_range(0, 12),
                                   0, 1'b1, -1);
            end else if (pick == 7) begin
                pkt = build_packet(ihl, random_options(ihl * 4 - 20), $urandom_range(0, 6),
                                   0, 1'b0, -1);
            end else if (pick == 8) begin
                // broken: odd IHL, damaged option, skewed length, cut short
                ihl  = $urandom_range(0, 15);
                opts = random_options(ihl * 4 - 20);
                if (opts.size() > 0)
                    opts[$urandom_range(0, opts.size() - 1)] = 8'($urandom);
                pkt = build_packet(ihl, opts, $urandom_range(0, 6),
                                   $urandom_range(0, 4) - 2, 1'b1, -1);
                if ($urandom_range(0, 1))
                    pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
            end else begin
                pkt.delete();
                repeat ($urandom_range(1, 30)) add_octet(pkt, 8'($urandom));
            end
            send_packet(pkt);
        end

        quiesce();
        $display("Summary: %0d packets, %0d bytes parsed, %0d results checked",
                 packets_sent, board.byte_total, board.result_total);
        $display("Covered option walk, every error status, a long output stall, %0d %s",
                 sum_writes, "checksum-enable writes");
        if (board.fail_total == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== ipv4_header_parser.f =====
hw/rtl/ipv4hp_pkg.sv
hw/rtl/ipv4hp_if.sv
hw/rtl/ipv4hp_parse.sv
hw/rtl/ipv4hp_resq.sv
hw/rtl/ipv4_header_parser.sv
tb/tb_ipv4_header_parser.sv
